// ===== src/smap_pkg.sv =====
`default_nettype none

package smap_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 64;
    localparam int KEY_BITS      = 12;
    localparam int ADDRESS_BITS  = 12;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // Field widths on the stream ports
    localparam int MODE_W        = 2;
    localparam int NAME_KEY_W    = 13;
    localparam int CODE_ADDR_W   = 12;
    localparam int ENTRY_INDEX_W = 6;
    localparam int STATUS_W      = 3;
    localparam int FOUND_W       = 12;
    localparam int STORED_W      = 12;
    localparam int COUNT_W       = 7;

    localparam int S_FIELDS_W = MODE_W + NAME_KEY_W + CODE_ADDR_W + ENTRY_INDEX_W;
    localparam int M_FIELDS_W = STATUS_W + FOUND_W + STORED_W + COUNT_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Width compare for index range checks
    localparam int CMP_W = (CNT_W > ENTRY_INDEX_W) ? CNT_W : ENTRY_INDEX_W;

    // Data returned by a selected cell (key or address), plus hit flag on top
    localparam int DATA_W = (KEY_BITS > ADDRESS_BITS) ? KEY_BITS : ADDRESS_BITS;

    // Reduction grouping
    localparam int GROUP_SIZE  = 8;
    localparam int NUM_GROUPS  = (TABLE_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_ENTRIES = NUM_GROUPS * GROUP_SIZE;

    // Bits of the raw name key that may be set for a valid key (sign bit never)
    localparam logic [NAME_KEY_W-1:0] KEY_LIMIT_MASK =
        (KEY_BITS >= NAME_KEY_W - 1) ? {1'b0, {(NAME_KEY_W-1){1'b1}}}
                                     : NAME_KEY_W'((1 << KEY_BITS) - 1);

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ_INDEX = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_ADDED       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERWRITTEN = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL        = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_HIT         = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_MISS        = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_BAD         = 3'd5;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_GRP,
        S_RES
    } state_t;

    // Hit flag in the top bit, selected data below
    typedef logic [DATA_W:0] hit_val_t;

    // Contents of one table entry, handed from cell to cell on append
    typedef struct packed {
        logic                    valid;
        logic [KEY_BITS-1:0]     key;
        logic [ADDRESS_BITS-1:0] addr;
    } entry_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                    cmp_en;
        logic                    by_index;
        logic [KEY_BITS-1:0]     key;
        logic [IDX_W-1:0]        pos;
        logic                    shift;
        logic                    update;
        logic [ADDRESS_BITS-1:0] addr;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/smap_cell.sv =====
`default_nettype none

module smap_cell (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire smap_pkg::cell_ctrl_t           ctrl,
    input  wire logic [smap_pkg::IDX_W-1:0]     my_pos,
    input  wire smap_pkg::entry_t               prev_entry,
    output smap_pkg::entry_t                    this_entry,
    output smap_pkg::hit_val_t                  hit_val
);

    logic                              valid_reg;
    logic                              sel_reg;
    logic [smap_pkg::KEY_BITS-1:0]     key_reg;
    logic [smap_pkg::ADDRESS_BITS-1:0] addr_reg;
    logic                              match;

    // Compare this entry against the broadcast key or position
    always_comb begin
        if (ctrl.by_index) begin
            match = valid_reg && (ctrl.pos == my_pos);
        end else begin
            match = valid_reg && (ctrl.key == key_reg);
        end
    end

    // Hold the valid flag and the match result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else begin
            if (ctrl.shift) begin
                valid_reg <= prev_entry.valid;
            end
            if (ctrl.cmp_en) begin
                sel_reg <= match;
            end
        end
    end

    // Take the neighbour's entry on append, or overwrite the address on a match
    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            key_reg  <= prev_entry.key;
            addr_reg <= prev_entry.addr;
        end else if (ctrl.update && sel_reg) begin
            addr_reg <= ctrl.addr;
        end
    end

    assign this_entry.valid = valid_reg;
    assign this_entry.key   = key_reg;
    assign this_entry.addr  = addr_reg;

    // Drive the selected data onto the reduction, zero when not selected
    always_comb begin
        if (!sel_reg) begin
            hit_val = '0;
        end else if (ctrl.by_index) begin
            hit_val = {1'b1, smap_pkg::DATA_W'(key_reg)};
        end else begin
            hit_val = {1'b1, smap_pkg::DATA_W'(addr_reg)};
        end
    end

endmodule

`default_nettype wire

// ===== src/smap_group.sv =====
`default_nettype none

module smap_group (
    input  wire logic               aclk,
    input  wire smap_pkg::hit_val_t vals [smap_pkg::GROUP_SIZE],
    output smap_pkg::hit_val_t      group_reg
);

    smap_pkg::hit_val_t group_next;

    // OR the group; at most one cell in the table is selected
    always_comb begin
        group_next = '0;
        for (int i = 0; i < smap_pkg::GROUP_SIZE; i++) begin
            group_next = group_next | vals[i];
        end
    end

    always_ff @(posedge aclk) begin
        group_reg <= group_next;
    end

endmodule

`default_nettype wire

// ===== src/symbol_to_address_map_core.sv =====
// An input word passes the request, cell match, group and result registers on its way to m_axis.
// Each word walks compare, group reduce and resolve before the next input word is accepted.
// The result register lets the next input word be accepted while a result waits.
// Reset clears the entry count and every cell's valid flag at once; entry contents
// stay undefined until written, and no clearing pass is needed.
`default_nettype none

module symbol_to_address_map_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // mode[1:0], name_key[14:2], code_address[26:15], entry_index[32:27], zero pad
    input  wire logic [smap_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // status[2:0], found_address[14:3], stored_key[26:15], entry_count[33:27], zero pad
    output logic [smap_pkg::M_TDATA_W-1:0]       m_axis_tdata
);

    localparam int K_LO = smap_pkg::MODE_W;
    localparam int A_LO = K_LO + smap_pkg::NAME_KEY_W;
    localparam int I_LO = A_LO + smap_pkg::CODE_ADDR_W;

    smap_pkg::state_t state_reg, state_next;

    // Request registers
    logic [smap_pkg::MODE_W-1:0]        mode_reg;
    logic [smap_pkg::NAME_KEY_W-1:0]    name_key_reg;
    logic [smap_pkg::CODE_ADDR_W-1:0]   code_addr_reg;
    logic [smap_pkg::ENTRY_INDEX_W-1:0] entry_idx_reg;

    logic [smap_pkg::CNT_W-1:0] count_reg, count_next;

    logic                            m_valid_reg, m_valid_next;
    logic [smap_pkg::M_TDATA_W-1:0]  m_data_reg, m_data_next;

    smap_pkg::cell_ctrl_t ctrl;
    smap_pkg::entry_t     chain [smap_pkg::TABLE_ENTRIES+1];
    smap_pkg::hit_val_t   cell_vals [smap_pkg::PAD_ENTRIES];
    smap_pkg::hit_val_t   group_vals [smap_pkg::NUM_GROUPS];
    smap_pkg::hit_val_t   final_val;

    logic                                key_ok;
    logic                                idx_ok;
    logic                                table_full;
    logic [smap_pkg::CNT_W-1:0]          pos_wide;
    logic                                out_free;
    logic                                fire;
    logic                                do_append;
    logic                                do_update;
    logic [smap_pkg::STATUS_W-1:0]       status;
    logic [smap_pkg::FOUND_W-1:0]        found_address;
    logic [smap_pkg::STORED_W-1:0]       stored_key;
    logic [smap_pkg::CNT_W-1:0]          count_after;

    // Capture the request word
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            mode_reg      <= s_axis_tdata[smap_pkg::MODE_W-1:0];
            name_key_reg  <= s_axis_tdata[A_LO-1:K_LO];
            code_addr_reg <= s_axis_tdata[I_LO-1:A_LO];
            entry_idx_reg <= s_axis_tdata[I_LO+smap_pkg::ENTRY_INDEX_W-1:I_LO];
        end
    end

    // Request qualifiers
    assign key_ok     = (name_key_reg & ~smap_pkg::KEY_LIMIT_MASK) == '0;
    assign idx_ok     = smap_pkg::CMP_W'(entry_idx_reg) < smap_pkg::CMP_W'(count_reg);
    assign pos_wide   = count_reg - smap_pkg::CNT_W'(1) - smap_pkg::CNT_W'(entry_idx_reg);
    assign table_full = chain[smap_pkg::TABLE_ENTRIES].valid;
    assign out_free   = !m_valid_reg || m_axis_tready;

    // Broadcast control to the cells
    always_comb begin
        ctrl.cmp_en   = (state_reg == smap_pkg::S_CMP);
        ctrl.by_index = (mode_reg == smap_pkg::MODE_READ_INDEX);
        ctrl.key      = smap_pkg::KEY_BITS'(name_key_reg);
        ctrl.pos      = pos_wide[smap_pkg::IDX_W-1:0];
        ctrl.shift    = do_append;
        ctrl.update   = do_update;
        ctrl.addr     = smap_pkg::ADDRESS_BITS'(code_addr_reg);
    end

    // New entries enter at the head of the chain
    assign chain[0].valid = 1'b1;
    assign chain[0].key   = ctrl.key;
    assign chain[0].addr  = ctrl.addr;

    // Row of entry cells; cell p holds entry index count-1-p
    for (genvar p = 0; p < smap_pkg::TABLE_ENTRIES; p++) begin : g_cell
        smap_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .my_pos     (smap_pkg::IDX_W'(p)),
            .prev_entry (chain[p]),
            .this_entry (chain[p+1]),
            .hit_val    (cell_vals[p])
        );
    end

    for (genvar p = smap_pkg::TABLE_ENTRIES; p < smap_pkg::PAD_ENTRIES; p++) begin : g_pad
        assign cell_vals[p] = '0;
    end

    // First reduction level, registered per group
    for (genvar g = 0; g < smap_pkg::NUM_GROUPS; g++) begin : g_group
        smap_group u_group (
            .aclk      (aclk),
            .vals      (cell_vals[g*smap_pkg::GROUP_SIZE +: smap_pkg::GROUP_SIZE]),
            .group_reg (group_vals[g])
        );
    end

    // Final reduction over the groups
    always_comb begin
        final_val = '0;
        for (int g = 0; g < smap_pkg::NUM_GROUPS; g++) begin
            final_val = final_val | group_vals[g];
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            smap_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = smap_pkg::S_CMP;
                end
            end
            smap_pkg::S_CMP: state_next = smap_pkg::S_GRP;
            smap_pkg::S_GRP: state_next = smap_pkg::S_RES;
            smap_pkg::S_RES: begin
                if (out_free) begin
                    state_next = smap_pkg::S_IDLE;
                end
            end
            default: state_next = smap_pkg::S_IDLE;
        endcase
    end

    // Resolve the operation from the reduced hit
    always_comb begin
        status        = smap_pkg::STAT_BAD;
        found_address = '0;
        stored_key    = '0;
        do_append     = 1'b0;
        do_update     = 1'b0;
        fire          = (state_reg == smap_pkg::S_RES) && out_free;
        s_axis_tready = (state_reg == smap_pkg::S_IDLE);
        case (mode_reg)
            smap_pkg::MODE_INSERT: begin
                if (key_ok) begin
                    if (final_val[smap_pkg::DATA_W]) begin
                        status    = smap_pkg::STAT_OVERWRITTEN;
                        do_update = fire;
                    end else if (table_full) begin
                        status = smap_pkg::STAT_FULL;
                    end else begin
                        status    = smap_pkg::STAT_ADDED;
                        do_append = fire;
                    end
                end
            end
            smap_pkg::MODE_LOOKUP: begin
                status = smap_pkg::STAT_MISS;
                if (key_ok && final_val[smap_pkg::DATA_W]) begin
                    status        = smap_pkg::STAT_HIT;
                    found_address = smap_pkg::FOUND_W'(
                        final_val[smap_pkg::ADDRESS_BITS-1:0]);
                end
            end
            smap_pkg::MODE_READ_INDEX: begin
                if (idx_ok) begin
                    status     = smap_pkg::STAT_HIT;
                    stored_key = smap_pkg::STORED_W'(final_val[smap_pkg::KEY_BITS-1:0]);
                end
            end
            default: status = smap_pkg::STAT_BAD;
        endcase
    end

    // Count and result word
    always_comb begin
        count_after = do_append ? count_reg + smap_pkg::CNT_W'(1) : count_reg;
        count_next  = count_after;
        m_data_next = m_data_reg;
        if (fire) begin
            m_data_next = smap_pkg::M_TDATA_W'({smap_pkg::COUNT_W'(count_after),
                                               stored_key, found_address, status});
        end
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= smap_pkg::S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ===== src/smap_checker.sv =====
`default_nettype none

module smap_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [smap_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    logic [smap_pkg::STATUS_W-1:0] status;
    logic [smap_pkg::FOUND_W-1:0]  found_address;
    logic [smap_pkg::STORED_W-1:0] stored_key;
    logic [smap_pkg::COUNT_W-1:0]  entry_count;

    // Split the result word
    assign status        = m_axis_tdata[2:0];
    assign found_address = m_axis_tdata[14:3];
    assign stored_key    = m_axis_tdata[26:15];
    assign entry_count   = m_axis_tdata[33:27];

    // Entry count never passes the table size
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> entry_count <= smap_pkg::COUNT_W'(smap_pkg::TABLE_ENTRIES))
        else $error("entry count beyond table size");

    // Returned data is zero unless the status is a hit
    a_zero_on_nohit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && status != smap_pkg::STAT_HIT) |->
            (found_address == '0 && stored_key == '0))
        else $error("result data set without a hit");

    // Status stays within the defined codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> status <= smap_pkg::STAT_BAD)
        else $error("undefined status code");

    // One word in flight: no accept on the cycle after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a word is in flight");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind symbol_to_address_map_core smap_checker u_smap_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
